// ----- hdl/pqxm_pkg.sv -----
// Package for the extract-max priority queue: default sizes, mode codes,
// controller states and the command/status structs between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package pqxm_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int PRIO_BITS_DEF = 16;
    localparam int DATA_BITS_DEF = 16;

    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } pqxm_state_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic shift;
        logic finish;
    } pqxm_cmd_t;

    typedef struct packed {
        logic mode;
        logic empty;
        logic last;
        logic shift_needed;
        logic out_free;
    } pqxm_stat_t;

endpackage

// ----- hdl/pqxm_req_if.sv -----
// Request channel of the priority queue: valid/ready plus one request word.
// Depends on nothing.
`timescale 1ns / 1ps

interface pqxm_req_if #(
    parameter int PRIO_BITS = 16,
    parameter int DATA_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [PRIO_BITS-1:0] priority_req;
    logic [DATA_BITS-1:0] payload;

    modport source (output valid, mode, priority_req, payload, input ready);
    modport sink   (input valid, mode, priority_req, payload, output ready);
endinterface

// ----- hdl/pqxm_rsp_if.sv -----
// Response channel of the priority queue: valid/ready plus one result word.
// Depends on nothing.
`timescale 1ns / 1ps

interface pqxm_rsp_if #(
    parameter int PRIO_BITS = 16,
    parameter int DATA_BITS = 16,
    parameter int CNT_BITS  = 5
);
    logic                 valid;
    logic                 ready;
    logic                 item_valid;
    logic [PRIO_BITS-1:0] out_priority;
    logic [DATA_BITS-1:0] out_payload;
    logic                 insert_dropped;
    logic [CNT_BITS-1:0]  entries_after;
    logic                 is_empty;

    modport source (output valid, item_valid, out_priority, out_payload, insert_dropped,
                    entries_after, is_empty, input ready);
    modport sink   (input valid, item_valid, out_priority, out_payload, insert_dropped,
                    entries_after, is_empty, output ready);
endinterface

// ----- hdl/priority_queue_extract_max.sv -----
// Channel  Dir  Word contents
// req      in   mode, priority_req, payload
// rsp      out  item_valid, out_priority, out_payload, insert_dropped,
//               entries_after, is_empty
//
// An insert goes from the accepting cycle straight to ST_FINISH, which loads the result
// register. An extract with n stored entries whose winner sits at slot b passes through
// ST_SCAN and, unless b is the last slot, ST_SHIFT before ST_FINISH: one comparator
// scans one slot per cycle through the registered RAM read port, then the entries behind
// the winner move up one slot per cycle. A new request is accepted once the previous
// result is in the output register, even while that result still waits for rsp.ready; a
// finished result that finds the output register still occupied holds until rsp.ready.
// Reset clears the entry count; the entry RAM needs no clearing.
// Top level of the priority queue; depends on pqxm_pkg, the two channel
// interfaces, pqxm_ctrl and pqxm_dp.
`timescale 1ns / 1ps

module priority_queue_extract_max #(
    parameter int DEPTH     = pqxm_pkg::DEPTH_DEF,
    parameter int PRIO_BITS = pqxm_pkg::PRIO_BITS_DEF,
    parameter int DATA_BITS = pqxm_pkg::DATA_BITS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    pqxm_req_if.sink   req,
    pqxm_rsp_if.source rsp
);

    localparam int CNT_BITS = $clog2(DEPTH + 1);

    pqxm_pkg::pqxm_cmd_t  cmd;
    pqxm_pkg::pqxm_stat_t stat;

    pqxm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pqxm_dp #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS),
        .DATA_BITS (DATA_BITS),
        .CNT_BITS  (CNT_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_mode        (req.mode),
        .in_priority    (req.priority_req),
        .in_payload     (req.payload),
        .out_ready      (rsp.ready),
        .out_valid      (rsp.valid),
        .item_valid     (rsp.item_valid),
        .out_priority   (rsp.out_priority),
        .out_payload    (rsp.out_payload),
        .insert_dropped (rsp.insert_dropped),
        .entries_after  (rsp.entries_after),
        .is_empty       (rsp.is_empty)
    );

endmodule

// ----- hdl/pqxm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module pqxm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/pqxm_ctrl.sv -----
// Controller of the priority queue: sequences accept, scan, shift and result load.
// Depends on pqxm_pkg.
`timescale 1ns / 1ps

module pqxm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  pqxm_pkg::pqxm_stat_t stat,
    output pqxm_pkg::pqxm_cmd_t  cmd
);

    pqxm_pkg::pqxm_state_t state_reg;
    pqxm_pkg::pqxm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pqxm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pqxm_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    // Inserts and extracts from an empty queue finish at once.
                    if (stat.mode == pqxm_pkg::MODE_EXTRACT && !stat.empty)
                    begin
                        state_next = pqxm_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = pqxm_pkg::ST_FINISH;
                    end
                end
            end
            pqxm_pkg::ST_SCAN:
            begin
                if (stat.last)
                begin
                    state_next = stat.shift_needed ? pqxm_pkg::ST_SHIFT : pqxm_pkg::ST_FINISH;
                end
            end
            pqxm_pkg::ST_SHIFT:
            begin
                if (stat.last)
                begin
                    state_next = pqxm_pkg::ST_FINISH;
                end
            end
            pqxm_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = pqxm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pqxm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        cmd        = '0;
        case (state_reg)
            pqxm_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.start = req_valid;
            end
            pqxm_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            pqxm_pkg::ST_SHIFT:
            begin
                cmd.shift = 1'b1;
            end
            pqxm_pkg::ST_FINISH:
            begin
                cmd.finish = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- hdl/pqxm_dp.sv -----
// Datapath of the priority queue: entry RAM, count, scan comparator, compaction
// and the output register. Depends on pqxm_pkg and pqxm_ram.
`timescale 1ns / 1ps

module pqxm_dp #(
    parameter int DEPTH     = pqxm_pkg::DEPTH_DEF,
    parameter int PRIO_BITS = pqxm_pkg::PRIO_BITS_DEF,
    parameter int DATA_BITS = pqxm_pkg::DATA_BITS_DEF,
    parameter int CNT_BITS  = $clog2(DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pqxm_pkg::pqxm_cmd_t  cmd,
    output pqxm_pkg::pqxm_stat_t stat,
    input  logic                 in_mode,
    input  logic [PRIO_BITS-1:0] in_priority,
    input  logic [DATA_BITS-1:0] in_payload,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic                 item_valid,
    output logic [PRIO_BITS-1:0] out_priority,
    output logic [DATA_BITS-1:0] out_payload,
    output logic                 insert_dropped,
    output logic [CNT_BITS-1:0]  entries_after,
    output logic                 is_empty
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WORD_W = PRIO_BITS + DATA_BITS;

    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [CNT_BITS-1:0]  rd_idx_reg, rd_idx_next;
    logic [CNT_BITS-1:0]  best_idx_reg, best_idx_next;
    logic [PRIO_BITS-1:0] best_prio_reg, best_prio_next;
    logic [DATA_BITS-1:0] best_data_reg, best_data_next;
    logic                 res_item_reg, res_item_next;
    logic                 res_drop_reg, res_drop_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_item_reg;
    logic [PRIO_BITS-1:0] out_prio_reg;
    logic [DATA_BITS-1:0] out_data_reg;
    logic                 out_drop_reg;
    logic [CNT_BITS-1:0]  out_count_reg;
    logic                 out_empty_reg;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;
    logic [PRIO_BITS-1:0] rd_prio;
    logic [DATA_BITS-1:0] rd_data;

    logic                 full;
    logic                 take;
    logic [CNT_BITS-1:0]  best_sel;
    logic [CNT_BITS-1:0]  idx_inc;
    logic [CNT_BITS-1:0]  best_inc;
    logic [CNT_BITS-1:0]  idx_dec;
    logic                 rd_last;
    logic                 out_free;

    pqxm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_prio  = ram_rdata[WORD_W-1:DATA_BITS];
    assign rd_data  = ram_rdata[DATA_BITS-1:0];
    assign full     = (count_reg == CNT_BITS'(DEPTH));
    // The first slot read always becomes the running best; later ones only on a
    // strictly greater priority, so the oldest of equal priorities wins.
    assign take     = (rd_idx_reg == '0) || (rd_prio > best_prio_reg);
    assign best_sel = take ? rd_idx_reg : best_idx_reg;
    assign idx_inc  = rd_idx_reg + 1'b1;
    assign best_inc = best_sel + 1'b1;
    assign idx_dec  = rd_idx_reg - 1'b1;
    assign rd_last  = (idx_inc == count_reg);
    assign out_free = !out_valid_reg || out_ready;

    assign stat.mode         = in_mode;
    assign stat.empty        = (count_reg == '0);
    assign stat.last         = rd_last;
    assign stat.shift_needed = (best_inc != count_reg);
    assign stat.out_free     = out_free;

    always_comb
    begin
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        best_idx_next  = best_idx_reg;
        best_prio_next = best_prio_reg;
        best_data_next = best_data_reg;
        res_item_next  = res_item_reg;
        res_drop_next  = res_drop_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[ADDR_W-1:0];
        ram_wdata      = {in_priority, in_payload};

        if (cmd.start)
        begin
            res_item_next = 1'b0;
            rd_idx_next   = '0;
            if (in_mode == pqxm_pkg::MODE_INSERT)
            begin
                res_drop_next = full;
                if (!full)
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                res_drop_next = 1'b0;
            end
        end

        if (cmd.scan)
        begin
            best_idx_next  = best_sel;
            best_prio_next = take ? rd_prio : best_prio_reg;
            best_data_next = take ? rd_data : best_data_reg;
            res_item_next  = 1'b1;
            // After the last slot, continue reading just past the winner.
            rd_idx_next    = rd_last ? best_inc : idx_inc;
        end

        if (cmd.shift)
        begin
            ram_we    = 1'b1;
            ram_waddr = idx_dec[ADDR_W-1:0];
            ram_wdata = ram_rdata;
            if (!rd_last)
            begin
                rd_idx_next = idx_inc;
            end
        end

        if (cmd.finish && res_item_reg)
        begin
            count_next = count_reg - 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign ram_raddr = rd_idx_next[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            res_item_reg  <= 1'b0;
            res_drop_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            res_item_reg  <= res_item_next;
            res_drop_reg  <= res_drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg  <= best_idx_next;
        best_prio_reg <= best_prio_next;
        best_data_reg <= best_data_next;
        if (cmd.finish)
        begin
            out_item_reg  <= res_item_reg;
            out_prio_reg  <= res_item_reg ? best_prio_reg : '0;
            out_data_reg  <= res_item_reg ? best_data_reg : '0;
            out_drop_reg  <= res_drop_reg;
            out_count_reg <= count_next;
            out_empty_reg <= (count_next == '0);
        end
    end

    assign out_valid      = out_valid_reg;
    assign item_valid     = out_item_reg;
    assign out_priority   = out_prio_reg;
    assign out_payload    = out_data_reg;
    assign insert_dropped = out_drop_reg;
    assign entries_after  = out_count_reg;
    assign is_empty       = out_empty_reg;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for priority_queue_extract_max: drives insert and extract
// words through the request channel and checks every result word against a queue model.
// Depends on pqxm_pkg, pqxm_req_if, pqxm_rsp_if and the priority_queue_extract_max RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int QUEUE_DEPTH = pqxm_pkg::DEPTH_DEF;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic        item_valid;
        logic [15:0] out_priority;
        logic [15:0] out_payload;
        logic        insert_dropped;
        logic [4:0]  entries_after;
        logic        is_empty;
    } pq_result_t;

    logic clk;
    logic rst_n;

    pqxm_req_if req_ch ();
    pqxm_rsp_if rsp_ch ();

    priority_queue_extract_max uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the stored entries, oldest first.
    logic [15:0] held_prio[$];
    logic [15:0] held_data[$];
    pq_result_t  pending_results[$];

    int  error_count;
    int  checked_count;
    int  insert_count;
    int  extract_count;
    int  dropped_count;
    int  empty_extract_count;
    int  full_hits;
    int  idle_cycles;
    bit  calm;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic pq_result_t predict_request(logic mode, logic [15:0] prio,
                                                   logic [15:0] data);
        pq_result_t r;
        int         best;
        r = '0;
        if (mode == pqxm_pkg::MODE_INSERT)
        begin
            if (held_prio.size() >= QUEUE_DEPTH)
            begin
                r.insert_dropped = 1'b1;
            end
            else
            begin
                held_prio.push_back(prio);
                held_data.push_back(data);
            end
        end
        else if (held_prio.size() > 0)
        begin
            // Strict compare from the oldest entry, so the earliest of equal priorities wins.
            best = 0;
            for (int i = 1; i < held_prio.size(); i++)
            begin
                if (held_prio[i] > held_prio[best])
                    best = i;
            end
            r.item_valid   = 1'b1;
            r.out_priority = held_prio[best];
            r.out_payload  = held_data[best];
            held_prio.delete(best);
            held_data.delete(best);
        end
        r.entries_after = 5'(held_prio.size());
        r.is_empty      = (held_prio.size() == 0);
        return r;
    endfunction

    task automatic send_word(input logic mode, input logic [15:0] prio, input logic [15:0] data);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid        = 1'b1;
        req_ch.mode         = mode;
        req_ch.priority_req = prio;
        req_ch.payload      = data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (mode == pqxm_pkg::MODE_INSERT)
        begin
            insert_count++;
            if (held_prio.size() >= QUEUE_DEPTH)
                dropped_count++;
        end
        else
        begin
            extract_count++;
            if (held_prio.size() == 0)
                empty_extract_count++;
        end
        pending_results.push_back(predict_request(mode, prio, data));
        if (held_prio.size() == QUEUE_DEPTH)
            full_hits++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // Result side: random stalls on ready, each accepted word checked against the oldest
    // prediction.
    initial
    begin : result_checker
        int         stall;
        pq_result_t want;
        rsp_ch.ready = 1'b0;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_ch.ready = 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready = 1'b1;
            end
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                checked_count++;
                if (pending_results.size() == 0)
                begin
                    $error("result word arrived with no request outstanding");
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("item_valid", 32'(want.item_valid),
                                32'(rsp_ch.item_valid));
                    check_field("out_priority", 32'(want.out_priority),
                                32'(rsp_ch.out_priority));
                    check_field("out_payload", 32'(want.out_payload),
                                32'(rsp_ch.out_payload));
                    check_field("insert_dropped", 32'(want.insert_dropped),
                                32'(rsp_ch.insert_dropped));
                    check_field("entries_after", 32'(want.entries_after),
                                32'(rsp_ch.entries_after));
                    check_field("is_empty", 32'(want.is_empty),
                                32'(rsp_ch.is_empty));
                end
                stall = draw_wait();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic test_empty_queue();
        send_word(pqxm_pkg::MODE_EXTRACT, 16'hFFFF, 16'hFFFF);
        send_word(pqxm_pkg::MODE_INSERT, 16'h1234, 16'hABCD);
        send_word(pqxm_pkg::MODE_EXTRACT, 16'h0000, 16'h0000);
        send_word(pqxm_pkg::MODE_EXTRACT, 16'h5555, 16'hAAAA);
    endtask

    task automatic test_ties_and_extremes();
        send_word(pqxm_pkg::MODE_INSERT, 16'h0000, 16'hFFFF);
        send_word(pqxm_pkg::MODE_INSERT, 16'hFFFF, 16'h0000);
        send_word(pqxm_pkg::MODE_INSERT, 16'hFFFF, 16'h1111);
        send_word(pqxm_pkg::MODE_INSERT, 16'h8000, 16'h5555);
        send_word(pqxm_pkg::MODE_EXTRACT, 16'hAAAA, 16'h5555);
        send_word(pqxm_pkg::MODE_EXTRACT, 16'h0000, 16'h0000);
        send_word(pqxm_pkg::MODE_EXTRACT, 16'h0000, 16'h0000);
        send_word(pqxm_pkg::MODE_EXTRACT, 16'h0000, 16'h0000);
    endtask

    task automatic test_fill_to_full();
        calm = 1'b1;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_word(pqxm_pkg::MODE_INSERT, 16'($urandom_range(0, 2)), 16'(i));
        send_word(pqxm_pkg::MODE_INSERT, 16'hFFFF, 16'hFFFF);
        calm = 1'b0;
        send_word(pqxm_pkg::MODE_INSERT, 16'h0001, 16'h0001);
        // Let everything settle before the random traffic starts from a full queue.
        wait_drained();
    endtask

    function automatic logic [15:0] draw_priority(int kind);
        case (kind)
            0: return 16'($urandom_range(0, 3));
            1: return 16'($urandom_range(16'hFFFC, 16'hFFFF));
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    2: return 16'h8000;
                    default: return 16'h7FFF;
                endcase
            end
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    task automatic test_random_traffic(input int item_total);
        int   sent;
        int   burst;
        int   insert_pct;
        int   prio_kind;
        logic mode;
        sent = 0;
        while (sent < item_total)
        begin
            burst = $urandom_range(10, 60);
            // The insert bias per burst walks the fill level between empty and full.
            case ($urandom_range(0, 3))
                0: insert_pct = 25;
                1: insert_pct = 50;
                2: insert_pct = 70;
                default: insert_pct = 90;
            endcase
            prio_kind = $urandom_range(0, 4);
            calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < burst && sent < item_total; k++)
            begin
                mode = ($urandom_range(0, 99) < insert_pct) ? pqxm_pkg::MODE_INSERT
                                                             : pqxm_pkg::MODE_EXTRACT;
                send_word(mode, draw_priority(prio_kind), 16'($urandom_range(0, 16'hFFFF)));
                sent++;
            end
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.mode         = pqxm_pkg::MODE_INSERT;
        req_ch.priority_req = '0;
        req_ch.payload      = '0;
        error_count         = 0;
        checked_count       = 0;
        insert_count        = 0;
        extract_count       = 0;
        dropped_count       = 0;
        empty_extract_count = 0;
        full_hits           = 0;
        idle_cycles         = 0;
        calm                = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_queue();
        test_ties_and_extremes();
        test_fill_to_full();
        test_random_traffic(1700);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d inserts (%0d dropped on a full queue) and %0d extracts",
                 insert_count, dropped_count, extract_count);
        $display("(%0d on an empty queue); queue reached full %0d times, %0d results checked.",
                 empty_extract_count, full_hits, checked_count);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
